[rtl/h3x3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h3x3_pkg
// Shared widths, lane control type and fixed-point helpers for the
// homogeneous 3x3 transform accumulator.
// ----------------------------------------------------------------------------
package h3x3_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC   = 16;
    localparam int PROD_W = 2 * WORD_W;
    localparam int ACC_W  = WORD_W + FRAC + 2;
    localparam int SUM_W  = ACC_W + 2;
    localparam int NUM_W  = WORD_W + FRAC;
    localparam int LANES  = 3;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam word_t ONE_Q = word_t'(1) <<< FRAC;
    localparam word_t W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t W_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic [1:0] FN_IDENT = 2'd0;
    localparam logic [1:0] FN_MUL   = 2'd1;
    localparam logic [1:0] FN_INV   = 2'd2;

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic neg;
    } lane_ctl_t;

    typedef struct packed {
        logic [3:0] p;
        logic [3:0] q;
        logic [3:0] r;
        logic [3:0] s;
    } cof_idx_t;

    // Saturate a wide sum to the signed word range.
    function automatic word_t sat_word(input sum_t v);
        if (v > sum_t'(W_MAX)) begin
            return W_MAX;
        end else if (v < sum_t'(W_MIN)) begin
            return W_MIN;
        end
        return word_t'(v);
    endfunction

    // Identity entry at row-major position n.
    function automatic word_t ident(input logic [3:0] n);
        return (n == 4'd0 || n == 4'd4 || n == 4'd8) ? ONE_Q : '0;
    endfunction

    // Cofactor c[n] = p*q - r*s over entries of the current matrix.
    function automatic cof_idx_t cof_idx(input logic [3:0] n);
        cof_idx_t c;
        unique case (n)
            4'd0:    c = '{4'd4, 4'd8, 4'd5, 4'd7};
            4'd1:    c = '{4'd2, 4'd7, 4'd1, 4'd8};
            4'd2:    c = '{4'd1, 4'd5, 4'd2, 4'd4};
            4'd3:    c = '{4'd5, 4'd6, 4'd3, 4'd8};
            4'd4:    c = '{4'd0, 4'd8, 4'd2, 4'd6};
            4'd5:    c = '{4'd2, 4'd3, 4'd0, 4'd5};
            4'd6:    c = '{4'd3, 4'd7, 4'd4, 4'd6};
            4'd7:    c = '{4'd1, 4'd6, 4'd0, 4'd7};
            4'd8:    c = '{4'd0, 4'd4, 4'd1, 4'd3};
            default: c = '{4'd0, 4'd0, 4'd0, 4'd0};
        endcase
        return c;
    endfunction

endpackage

[rtl/h3x3_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h3x3_lane
// One multiply-accumulate lane: registered Q product, exact accumulate.
// ----------------------------------------------------------------------------
module h3x3_lane (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  h3x3_pkg::lane_ctl_t  ctl,
    input  h3x3_pkg::word_t      a,
    input  h3x3_pkg::word_t      b,
    output h3x3_pkg::acc_t       acc,
    output h3x3_pkg::word_t      acc_sat
);
    import h3x3_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     add_reg;
    logic                     neg_reg;
    acc_t                     acc_reg;
    acc_t                     term;

    // Truncate the product toward minus infinity.
    assign term = acc_t'(prod_reg >>> FRAC);

    // Register the product.
    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    // Accumulate the registered product, with its add and sign flags registered alongside.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            add_reg <= 1'b0;
            neg_reg <= 1'b0;
            acc_reg <= '0;
        end else begin
            add_reg <= ctl.mul_en;
            neg_reg <= ctl.neg;
            if (ctl.clr) begin
                acc_reg <= '0;
            end else if (add_reg) begin
                acc_reg <= neg_reg ? acc_reg - term : acc_reg + term;
            end
        end
    end

    assign acc     = acc_reg;
    assign acc_sat = sat_word(sum_t'(acc_reg));

endmodule

[rtl/h3x3_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h3x3_merge
// Combine the exact lane sums into the saturated determinant.
// ----------------------------------------------------------------------------
module h3x3_merge (
    input  h3x3_pkg::acc_t  acc0,
    input  h3x3_pkg::acc_t  acc1,
    input  h3x3_pkg::acc_t  acc2,
    output h3x3_pkg::word_t det
);
    import h3x3_pkg::*;

    sum_t total;

    // Sum exactly, saturate once.
    assign total = sum_t'(acc0) + sum_t'(acc1) + sum_t'(acc2);
    assign det   = sat_word(total);

endmodule

[rtl/h3x3_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h3x3_div
// Restoring divider, one quotient bit a cycle: (num << FRAC) / den,
// truncated toward zero and saturated to the word range.
// ----------------------------------------------------------------------------
module h3x3_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  h3x3_pkg::word_t num,
    input  h3x3_pkg::word_t den,
    output logic            done,
    output h3x3_pkg::word_t quot
);
    import h3x3_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  q_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] dmag_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic signed [NUM_W-1:0] num_w;
    logic [NUM_W-1:0]        nmag;
    logic [WORD_W:0]         rem_sh;
    logic [WORD_W:0]         rem_sub;

    assign num_w   = {num, {FRAC{1'b0}}};
    assign nmag    = num_w[NUM_W-1] ? NUM_W'(-num_w) : NUM_W'(num_w);
    assign rem_sh  = {rem_reg, q_reg[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, dmag_reg};

    // Iterate one bit per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                q_reg    <= nmag;
                rem_reg  <= '0;
                dmag_reg <= den[WORD_W-1] ? WORD_W'(-den) : WORD_W'(den);
                neg_reg  <= num[WORD_W-1] ^ den[WORD_W-1];
            end else if (busy_reg) begin
                if (!rem_sub[WORD_W]) begin
                    rem_reg <= rem_sub[WORD_W-1:0];
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[WORD_W-1:0];
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Apply sign and saturate.
    always_comb begin
        if (!neg_reg) begin
            quot = (q_reg > NUM_W'(W_MAX)) ? W_MAX : word_t'(q_reg);
        end else begin
            quot = (q_reg > (NUM_W'(1) << (WORD_W - 1))) ? W_MIN
                                                         : word_t'(-q_reg);
        end
    end

    assign done = done_reg;

endmodule

[rtl/homogeneous_3x3_transform_accumulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_3x3_transform_accumulator
// Current 3x3 Q16.16 transform: load identity, right-multiply, report inverse or the current matrix.
// ----------------------------------------------------------------------------
// One item at a time. Identity and unused codes go straight to the result;
// a multiply runs on three lanes, one row each, a registered multiplier
// each, one column at a time; an inverse forms the cofactors on the
// lanes, then the determinant, then makes three passes of the per-lane
// serial dividers. A finished result waits in the output register while
// the next item is taken.
// ----------------------------------------------------------------------------
module homogeneous_3x3_transform_accumulator (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_func,
    input  h3x3_pkg::word_t s_opnd_00,
    input  h3x3_pkg::word_t s_opnd_01,
    input  h3x3_pkg::word_t s_opnd_02,
    input  h3x3_pkg::word_t s_opnd_10,
    input  h3x3_pkg::word_t s_opnd_11,
    input  h3x3_pkg::word_t s_opnd_12,
    input  h3x3_pkg::word_t s_opnd_20,
    input  h3x3_pkg::word_t s_opnd_21,
    input  h3x3_pkg::word_t s_opnd_22,
    output logic            m_valid,
    input  logic            m_ready,
    output h3x3_pkg::word_t m_res_00,
    output h3x3_pkg::word_t m_res_01,
    output h3x3_pkg::word_t m_res_02,
    output h3x3_pkg::word_t m_res_10,
    output h3x3_pkg::word_t m_res_11,
    output h3x3_pkg::word_t m_res_12,
    output h3x3_pkg::word_t m_res_20,
    output h3x3_pkg::word_t m_res_21,
    output h3x3_pkg::word_t m_res_22,
    output logic            m_singular
);
    import h3x3_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_MFIN, ST_COF, ST_DET, ST_CHK, ST_DGO, ST_DWT, ST_DONE
    } state_t;

    state_t     state_reg;
    logic [1:0] elem_reg;
    logic [2:0] step_reg;
    word_t      cur_reg  [9];
    word_t      opnd_reg [9];
    word_t      r_reg    [9];
    word_t      c_reg    [9];
    word_t      det_reg;
    logic       sing_reg;
    word_t      out_reg  [9];
    logic       out_sing_reg;
    logic       m_valid_reg;

    word_t      s_opnd [9];
    lane_ctl_t  ctl    [LANES];
    word_t      la     [LANES];
    word_t      lb     [LANES];
    acc_t       lacc   [LANES];
    word_t      lsat   [LANES];
    word_t      dquot  [LANES];
    logic       ddone  [LANES];
    word_t      dnum   [LANES];
    word_t      det_w;
    logic       last_step;

    assign s_opnd = '{s_opnd_00, s_opnd_01, s_opnd_02, s_opnd_10, s_opnd_11,
                      s_opnd_12, s_opnd_20, s_opnd_21, s_opnd_22};
    assign s_ready   = (state_reg == ST_IDLE);
    assign last_step = (step_reg == 3'd5);

    // Route operands to the lanes for the current step.
    always_comb begin
        logic [3:0] n;
        logic [1:0] k;
        cof_idx_t   ci;
        for (int l = 0; l < LANES; l++) begin
            n  = 4'(l * 3) + 4'(elem_reg);
            k  = 2'(step_reg - 3'd1);
            ci = cof_idx(n);
            ctl[l] = '{clr: 1'b0, mul_en: 1'b0, neg: 1'b0};
            la[l]  = '0;
            lb[l]  = '0;
            dnum[l] = c_reg[n];
            unique case (state_reg)
                ST_MUL: begin
                    ctl[l].clr    = (step_reg == 3'd0);
                    ctl[l].mul_en = (step_reg >= 3'd1) && (step_reg <= 3'd3);
                    la[l] = cur_reg[4'(l * 3) + 4'(k)];
                    lb[l] = opnd_reg[4'(k) * 4'd3 + 4'(elem_reg)];
                end
                ST_COF: begin
                    ctl[l].clr    = (step_reg == 3'd0);
                    ctl[l].mul_en = (step_reg == 3'd1) || (step_reg == 3'd2);
                    ctl[l].neg    = (step_reg == 3'd2);
                    la[l] = (step_reg == 3'd2) ? cur_reg[ci.r] : cur_reg[ci.p];
                    lb[l] = (step_reg == 3'd2) ? cur_reg[ci.s] : cur_reg[ci.q];
                end
                ST_DET: begin
                    ctl[l].clr    = (step_reg == 3'd0);
                    ctl[l].mul_en = (step_reg == 3'd1);
                    la[l] = cur_reg[4'(l * 3)];
                    lb[l] = c_reg[l];
                end
                default: begin
                end
            endcase
        end
    end

    // Lanes, dividers and the determinant merge.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        h3x3_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl[g]),
            .a       (la[g]),
            .b       (lb[g]),
            .acc     (lacc[g]),
            .acc_sat (lsat[g])
        );
        h3x3_div u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (state_reg == ST_DGO),
            .num     (dnum[g]),
            .den     (det_reg),
            .done    (ddone[g]),
            .quot    (dquot[g])
        );
    end

    h3x3_merge u_merge (
        .acc0 (lacc[0]),
        .acc1 (lacc[1]),
        .acc2 (lacc[2]),
        .det  (det_w)
    );

    // Sequence one item and hold the results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            elem_reg    <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                cur_reg[i] <= ident(4'(i));
            end
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        opnd_reg <= s_opnd;
                        elem_reg <= '0;
                        step_reg <= '0;
                        sing_reg <= 1'b0;
                        priority if (s_func == FN_IDENT) begin
                            for (int i = 0; i < 9; i++) begin
                                cur_reg[i] <= ident(4'(i));
                                r_reg[i]   <= ident(4'(i));
                            end
                            state_reg <= ST_DONE;
                        end else if (s_func == FN_MUL) begin
                            state_reg <= ST_MUL;
                        end else if (s_func == FN_INV) begin
                            state_reg <= ST_COF;
                        end else begin
                            r_reg     <= cur_reg;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_MUL, ST_COF: begin
                    step_reg <= last_step ? 3'd0 : step_reg + 3'd1;
                    if (last_step) begin
                        for (int l = 0; l < LANES; l++) begin
                            if (state_reg == ST_MUL) begin
                                r_reg[4'(l * 3) + 4'(elem_reg)] <= lsat[l];
                            end else begin
                                c_reg[4'(l * 3) + 4'(elem_reg)] <= lsat[l];
                            end
                        end
                        elem_reg <= elem_reg + 2'd1;
                        if (elem_reg == 2'd2) begin
                            elem_reg  <= '0;
                            state_reg <= (state_reg == ST_MUL) ? ST_MFIN : ST_DET;
                        end
                    end
                end
                ST_MFIN: begin
                    cur_reg   <= r_reg;
                    state_reg <= ST_DONE;
                end
                ST_DET: begin
                    step_reg <= last_step ? 3'd0 : step_reg + 3'd1;
                    if (last_step) begin
                        det_reg   <= det_w;
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (det_reg == '0) begin
                        for (int i = 0; i < 9; i++) begin
                            r_reg[i] <= ident(4'(i));
                        end
                        sing_reg  <= 1'b1;
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_DGO;
                    end
                end
                ST_DGO: begin
                    state_reg <= ST_DWT;
                end
                ST_DWT: begin
                    if (ddone[0]) begin
                        for (int l = 0; l < LANES; l++) begin
                            r_reg[4'(l * 3) + 4'(elem_reg)] <= dquot[l];
                        end
                        elem_reg  <= elem_reg + 2'd1;
                        state_reg <= (elem_reg == 2'd2) ? ST_DONE : ST_DGO;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg      <= r_reg;
                        out_sing_reg <= sing_reg;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_singular = out_sing_reg;
    assign m_res_00   = out_reg[0];
    assign m_res_01   = out_reg[1];
    assign m_res_02   = out_reg[2];
    assign m_res_10   = out_reg[3];
    assign m_res_11   = out_reg[4];
    assign m_res_12   = out_reg[5];
    assign m_res_20   = out_reg[6];
    assign m_res_21   = out_reg[7];
    assign m_res_22   = out_reg[8];

    // The lanes stay quiet while no item is in work.
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !ctl[0].mul_en && !ctl[1].mul_en && !ctl[2].mul_en)
        else $error("lane active while idle");

    // A singular result always carries the identity.
    a_sing_ident: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_singular) |-> (m_res_00 == ONE_Q) && (m_res_01 == '0)
        && (m_res_11 == ONE_Q) && (m_res_22 == ONE_Q))
        else $error("singular result is not identity");

    // Division only starts on a nonzero determinant.
    a_div_det: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DGO) |-> (det_reg != '0))
        else $error("division started on zero determinant");

    // A result is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_res_00) && $stable(m_singular))
        else $error("pending result overwritten");

endmodule

[test/homogeneous_3x3_transform_accumulator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_3x3_transform_accumulator_tb
// Drives identity, multiply, inverse and unused codes through the block and
// checks every result against a local Q16.16 matrix predictor.
// ----------------------------------------------------------------------------
module homogeneous_3x3_transform_accumulator_tb;
    import h3x3_pkg::*;

    localparam int  MAX_CYCLES = 2000000;
    localparam logic [1:0] FN_NOP = 2'd3;

    typedef struct {
        logic signed [31:0] m [9];
        logic               sing;
    } xform_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_func = FN_IDENT;
    word_t s_opnd [9];
    logic m_valid;
    logic m_ready = 1'b0;
    word_t m_res [9];
    logic m_singular;

    xform_t expected_q [$];
    logic signed [63:0] cur_mat [9];
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_singular = 0;
    int cycles = 0;
    int hold_off = 0;
    bit rx_idle_en = 1'b1;
    bit tx_idle_en = 1'b1;

    initial begin
        for (int i = 0; i < 9; i++) s_opnd[i] = '0;
    end

    always #1 aclk = ~aclk;

    homogeneous_3x3_transform_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_opnd_00(s_opnd[0]), .s_opnd_01(s_opnd[1]), .s_opnd_02(s_opnd[2]),
        .s_opnd_10(s_opnd[3]), .s_opnd_11(s_opnd[4]), .s_opnd_12(s_opnd[5]),
        .s_opnd_20(s_opnd[6]), .s_opnd_21(s_opnd[7]), .s_opnd_22(s_opnd[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_res_00(m_res[0]), .m_res_01(m_res[1]), .m_res_02(m_res[2]),
        .m_res_10(m_res[3]), .m_res_11(m_res[4]), .m_res_12(m_res[5]),
        .m_res_20(m_res[6]), .m_res_21(m_res[7]), .m_res_22(m_res[8]),
        .m_singular(m_singular)
    );

    // Saturate to the signed 32-bit range.
    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 product, floor of the exact product.
    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic logic signed [63:0] cofac(input int p, input int q,
                                                 input int r, input int s);
        return clamp32(qmul(cur_mat[p], cur_mat[q]) - qmul(cur_mat[r], cur_mat[s]));
    endfunction

    // Apply one item to the tracked matrix and return the result it yields.
    function automatic xform_t predict_transform(input logic [1:0] fn,
                                                 input word_t b [9]);
        xform_t x;
        logic signed [63:0] nm [9];
        logic signed [63:0] c [9];
        logic signed [63:0] s, det;
        x.sing = 1'b0;
        case (fn)
            FN_IDENT: begin
                for (int i = 0; i < 9; i++) cur_mat[i] = (i % 4 == 0) ? 64'sd65536 : 0;
            end
            FN_MUL: begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) begin
                        s = 0;
                        for (int k = 0; k < 3; k++)
                            s += qmul(cur_mat[i*3+k], 64'(b[k*3+j]));
                        nm[i*3+j] = clamp32(s);
                    end
                for (int i = 0; i < 9; i++) cur_mat[i] = nm[i];
            end
            default: ;
        endcase
        for (int i = 0; i < 9; i++) x.m[i] = cur_mat[i][31:0];
        if (fn == FN_INV) begin
            c[0] = cofac(4, 8, 5, 7); c[1] = cofac(2, 7, 1, 8);
            c[2] = cofac(1, 5, 2, 4); c[3] = cofac(5, 6, 3, 8);
            c[4] = cofac(0, 8, 2, 6); c[5] = cofac(2, 3, 0, 5);
            c[6] = cofac(3, 7, 4, 6); c[7] = cofac(1, 6, 0, 7);
            c[8] = cofac(0, 4, 1, 3);
            det = clamp32(qmul(cur_mat[0], c[0]) + qmul(cur_mat[3], c[1])
                          + qmul(cur_mat[6], c[2]));
            if (det == 0) begin
                x.sing = 1'b1;
                for (int i = 0; i < 9; i++) x.m[i] = (i % 4 == 0) ? 32'sd65536 : 0;
            end else begin
                for (int i = 0; i < 9; i++)
                    x.m[i] = 32'(clamp32((c[i] * 64'sd65536) / det));
            end
        end
        return x;
    endfunction

    // Offer one item, after a random gap when tx_idle_en is set; hold it until accepted.
    task automatic send_item(input logic [1:0] fn, input word_t b [9]);
        int gap;
        gap = 0;
        if (tx_idle_en)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= fn;
        for (int i = 0; i < 9; i++) s_opnd[i] <= b[i];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_q.push_back(predict_transform(fn, b));
        n_items++;
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(0, 5))
            0: return W_MAX;
            1: return W_MIN;
            2: return word_t'($urandom);
            3: return word_t'(0);
            default: return word_t'($signed($urandom_range(0, 262143)) - 131072);
        endcase
    endfunction

    function automatic void fill_matrix(ref word_t b [9], input word_t diag,
                                        input word_t off);
        for (int i = 0; i < 9; i++) b[i] = (i % 4 == 0) ? diag : off;
    endfunction

    // Hold the receiver off at random when rx_idle_en is set, with a long stretch when asked.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else if (rx_idle_en) begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge aclk) begin
        xform_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result", $time);
                errors++;
            end else begin
                e = expected_q.pop_front();
                n_results++;
                if (e.sing) n_singular++;
                for (int i = 0; i < 9; i++)
                    if (m_res[i] !== e.m[i]) begin
                        $display("%0t: res[%0d] expected %0d got %0d",
                                 $time, i, e.m[i], m_res[i]);
                        errors++;
                    end
                if (m_singular !== e.sing) begin
                    $display("%0t: singular expected %0b got %0b",
                             $time, e.sing, m_singular);
                    errors++;
                end
            end
        end
    end

    // Stop a hung run.
    always @(posedge aclk) begin
        if (cycles >= MAX_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_directed();
        word_t b [9];
        fill_matrix(b, 0, 0);
        send_item(FN_INV, b);
        send_item(FN_NOP, b);
        fill_matrix(b, word_t'(32'sd131072), word_t'(32'sd65536));
        send_item(FN_MUL, b);
        send_item(FN_INV, b);
        fill_matrix(b, W_MAX, W_MAX);
        send_item(FN_MUL, b);
        send_item(FN_INV, b);
        fill_matrix(b, W_MIN, W_MAX);
        send_item(FN_MUL, b);
        send_item(FN_INV, b);
        fill_matrix(b, 0, 0);
        send_item(FN_MUL, b);
        send_item(FN_INV, b);
        fill_matrix(b, W_MIN, W_MIN);
        send_item(FN_IDENT, b);
        fill_matrix(b, word_t'(-32'sd1), word_t'(-32'sd1));
        send_item(FN_MUL, b);
        send_item(FN_INV, b);
        send_item(FN_NOP, b);
        send_item(FN_IDENT, b);
        fill_matrix(b, word_t'(32'sd1), 0);
        send_item(FN_MUL, b);
        send_item(FN_INV, b);
    endtask

    task automatic test_random(input int count);
        word_t b [9];
        logic [1:0] fn;
        for (int n = 0; n < count; n++) begin
            // Mostly well-scaled matrices so inverses stay meaningful.
            for (int i = 0; i < 9; i++)
                b[i] = ($urandom_range(0, 3) == 0) ? rand_word()
                     : word_t'($signed($urandom_range(0, 196608)) - 98304);
            case ($urandom_range(0, 9))
                0: fn = FN_IDENT;
                1: fn = FN_NOP;
                2, 3, 4: fn = FN_INV;
                default: fn = FN_MUL;
            endcase
            send_item(fn, b);
        end
    endtask

    task automatic test_back_pressure();
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        hold_off = 400;
        test_random(12);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_streaming();
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        test_random(80);
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
    endtask

    initial begin
        int drain;
        for (int i = 0; i < 9; i++) cur_mat[i] = (i % 4 == 0) ? 64'sd65536 : 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_back_pressure();
        test_streaming();
        test_random(700);
        s_valid <= 1'b0;
        drain = 0;
        while (expected_q.size() != 0 && drain < 200000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (300) @(posedge aclk);
        if (expected_q.size() != 0) begin
            $display("%0d results never arrived", expected_q.size());
            errors++;
        end
        $display("Sent %0d items, checked %0d results (%0d singular inverses)",
                 n_items, n_results, n_singular);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
